FILE: rtl/core/tx_frame_descriptor_segmenter_unit_assert.svh
// Assertion macros used by the transmit segmenter datapath.
`ifndef TX_FRAME_DESCRIPTOR_SEGMENTER_UNIT_ASSERT_SVH
`define TX_FRAME_DESCRIPTOR_SEGMENTER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Check that a condition holds at every clock edge outside reset.
`define TFDS_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tfds assertion failed");
// Check that a consequence holds in the same cycle as its trigger.
`define TFDS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfds assertion failed");
`else
`define TFDS_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define TFDS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/tfds_pkg.sv
// Types and constants of the transmit frame descriptor segmenter.
package tfds_pkg;

  localparam int SEGMENT_BYTES = 1524;
  localparam int MAX_SEGMENTS  = 43;
  localparam int LEN_W         = 16;
  localparam int SIZE_W        = 11;

  localparam logic [LEN_W-1:0]  SEG_LEN         = LEN_W'(SEGMENT_BYTES);
  localparam logic [SIZE_W-1:0] SEG_SIZE        = SIZE_W'(SEGMENT_BYTES);
  localparam logic [LEN_W:0]    MAX_FRAME_BYTES = (LEN_W+1)'(MAX_SEGMENTS * SEGMENT_BYTES);
  localparam logic [2:0]        TPS_SUSPENDED   = 3'd6;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_ZERO_LEN  = 2'd1,
    STAT_HEAD_BUSY = 2'd2,
    STAT_TOO_LONG  = 2'd3
  } stat_code_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } ctrl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
    logic is_last;
  } dp_stat_t;

endpackage

FILE: rtl/core/tfds_ctrl.sv
// Sequencer of the transmit segmenter: accepts a request, then paces entries.
module tfds_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tfds_pkg::dp_stat_t stat,
  output tfds_pkg::dp_cmd_t  cmd
);
  import tfds_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Advance one entry whenever the output register can take it.
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.is_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/tfds_dp.sv
// Datapath of the transmit segmenter: remaining length, flags, output register.
`include "tx_frame_descriptor_segmenter_unit_assert.svh"
module tfds_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  tfds_pkg::dp_cmd_t           cmd,
  output tfds_pkg::dp_stat_t          stat,
  input  logic [tfds_pkg::LEN_W-1:0]  frame_length,
  input  logic                        head_owned,
  input  logic [2:0]                  tx_process_state,
  input  logic                        buffer_unavailable,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tfds_pkg::SIZE_W-1:0] segment_size,
  output logic                        first_segment,
  output logic                        last_segment,
  output logic [1:0]                  status,
  output logic                        poll_demand,
  output logic                        clear_unavailable
);
  import tfds_pkg::*;

  logic [LEN_W-1:0] rem;
  stat_code_t       err;
  logic             first_pend;
  logic             poll_pend;
  logic             clr_pend;
  stat_code_t       err_next;
  logic             rem_fits;

  always_comb begin
    if (frame_length == '0) begin
      err_next = STAT_ZERO_LEN;
    end else if (head_owned) begin
      err_next = STAT_HEAD_BUSY;
    end else if ({1'b0, frame_length} > MAX_FRAME_BYTES) begin
      err_next = STAT_TOO_LONG;
    end else begin
      err_next = STAT_OK;
    end
  end

  assign rem_fits      = (rem <= SEG_LEN);
  assign stat.is_last  = (err != STAT_OK) || rem_fits;
  assign stat.out_free = !out_valid || !out_stall;

  // Request context.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem        <= frame_length;
      err        <= err_next;
      first_pend <= 1'b1;
      poll_pend  <= (tx_process_state == TPS_SUSPENDED) || buffer_unavailable;
      clr_pend   <= buffer_unavailable;
    end else if (cmd.emit && err == STAT_OK && !rem_fits) begin
      rem        <= rem - SEG_LEN;
      first_pend <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (err != STAT_OK) begin
        segment_size      <= '0;
        first_segment     <= 1'b0;
        last_segment      <= 1'b1;
        status            <= err;
        poll_demand       <= 1'b0;
        clear_unavailable <= 1'b0;
      end else if (rem_fits) begin
        segment_size      <= rem[SIZE_W-1:0];
        first_segment     <= first_pend;
        last_segment      <= 1'b1;
        status            <= STAT_OK;
        poll_demand       <= poll_pend;
        clear_unavailable <= clr_pend;
      end else begin
        segment_size      <= SEG_SIZE;
        first_segment     <= first_pend;
        last_segment      <= 1'b0;
        status            <= STAT_OK;
        poll_demand       <= 1'b0;
        clear_unavailable <= 1'b0;
      end
    end
  end

  `TFDS_ASSERT_IMPLIES(a_emit_free, clk, rst, cmd.emit, !out_valid || !out_stall)
  `TFDS_ASSERT_IMPLIES(a_kick_last, clk, rst, out_valid && (poll_demand || clear_unavailable), last_segment)
  `TFDS_ASSERT_IMPLIES(a_err_shape, clk, rst, out_valid && status != STAT_OK, last_segment && !first_segment && segment_size == '0)

endmodule

FILE: rtl/core/tx_frame_descriptor_segmenter_unit.sv
// Top level of the transmit frame descriptor segmenter.
//
//   channel   direction  handshake            payload
//   request   in         in_valid / in_stall  frame_length, head_owned,
//                                             tx_process_state, buffer_unavailable
//   entry     out        out_valid/out_stall  segment_size, first_segment,
//                                             last_segment, status,
//                                             poll_demand, clear_unavailable
//
// A request yields N entries (1 for a rejected request, ceil(length / SEGMENT_BYTES)
// otherwise); the sequencer accepts it, emits one entry per cycle into the output
// register while the entry side does not stall, and then returns to idle.
// Reset (rst, synchronous) returns the sequencer to idle and drops out_valid.
// A stall on the entry side holds the output register and pauses emission;
// in_stall is high from acceptance until the last entry of a request is loaded.
module tx_frame_descriptor_segmenter_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tfds_pkg::LEN_W-1:0]  frame_length,
  input  logic                        head_owned,
  input  logic [2:0]                  tx_process_state,
  input  logic                        buffer_unavailable,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tfds_pkg::SIZE_W-1:0] segment_size,
  output logic                        first_segment,
  output logic                        last_segment,
  output logic [1:0]                  status,
  output logic                        poll_demand,
  output logic                        clear_unavailable
);
  import tfds_pkg::*;

  // Commands from the sequencer, status back from the datapath.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer: hold off new requests while one is being split.
  tfds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: classify the request, count down the remaining bytes,
  // and drive the registered entry.
  tfds_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .frame_length       (frame_length),
    .head_owned         (head_owned),
    .tx_process_state   (tx_process_state),
    .buffer_unavailable (buffer_unavailable),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .segment_size       (segment_size),
    .first_segment      (first_segment),
    .last_segment       (last_segment),
    .status             (status),
    .poll_demand        (poll_demand),
    .clear_unavailable  (clear_unavailable)
  );

endmodule

FILE: tb/tb_tx_frame_descriptor_segmenter_unit.sv
// Testbench for the transmit frame descriptor segmenter: directed and random requests.
`timescale 1ns / 1ps

module tb_tx_frame_descriptor_segmenter_unit;
  import tfds_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int PRESSURE_ITEMS = 8;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int TAIL_CYCLES    = 16;
  localparam int MAX_GAP        = 20;

  typedef struct {
    logic [LEN_W-1:0] frame_length;
    logic             head_owned;
    logic [2:0]       tx_process_state;
    logic             buffer_unavailable;
  } tx_request_t;

  typedef struct {
    logic [SIZE_W-1:0] segment_size;
    logic              first_segment;
    logic              last_segment;
    logic [1:0]        status;
    logic              poll_demand;
    logic              clear_unavailable;
  } descriptor_t;

  // Hold the descriptor entries that accepted requests still owe, oldest first.
  class descriptor_ledger;
    descriptor_t queued[$];
    int mismatches;
    int requests_seen;
    int rejected_seen;
    int entries_seen;
    int most_entries;

    function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
        mismatches++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
      end
    endfunction

    // Split one request into the entries the block must emit for it.
    function void note_request(tx_request_t req);
      descriptor_t d;
      int count;
      int len;
      logic kick;
      len   = int'(req.frame_length);
      count = (len + SEGMENT_BYTES - 1) / SEGMENT_BYTES;
      requests_seen++;
      d.segment_size      = '0;
      d.first_segment     = 1'b0;
      d.last_segment      = 1'b1;
      d.status            = STAT_OK;
      d.poll_demand       = 1'b0;
      d.clear_unavailable = 1'b0;
      // Zero length wins over a busy head, and a busy head over an oversize frame.
      if (len == 0)
        d.status = STAT_ZERO_LEN;
      else if (req.head_owned)
        d.status = STAT_HEAD_BUSY;
      else if (count > MAX_SEGMENTS)
        d.status = STAT_TOO_LONG;
      if (d.status != STAT_OK) begin
        queued.push_back(d);
        rejected_seen++;
        return;
      end
      kick = (req.tx_process_state == TPS_SUSPENDED) || req.buffer_unavailable;
      for (int i = 0; i < count; i++) begin
        d.first_segment     = (i == 0);
        d.last_segment      = (i == count - 1);
        d.segment_size      = d.last_segment ? SIZE_W'(len - (count - 1) * SEGMENT_BYTES)
                                             : SEG_SIZE;
        d.poll_demand       = d.last_segment && kick;
        d.clear_unavailable = d.last_segment && req.buffer_unavailable;
        queued.push_back(d);
      end
      if (count > most_entries)
        most_entries = count;
    endfunction

    function void check_entry(descriptor_t got);
      descriptor_t want;
      entries_seen++;
      if (queued.size() == 0) begin
        mismatches++;
        $display("%0t: entry expected none, actual %0d/%0b/%0b/%0d/%0b/%0b",
                 $time, got.segment_size, got.first_segment, got.last_segment,
                 got.status, got.poll_demand, got.clear_unavailable);
        return;
      end
      want = queued.pop_front();
      compare_field("segment_size", want.segment_size, got.segment_size);
      compare_field("first_segment", want.first_segment, got.first_segment);
      compare_field("last_segment", want.last_segment, got.last_segment);
      compare_field("status", want.status, got.status);
      compare_field("poll_demand", want.poll_demand, got.poll_demand);
      compare_field("clear_unavailable", want.clear_unavailable, got.clear_unavailable);
    endfunction
  endclass

  logic              clk                = 1'b0;
  logic              rst                = 1'b1;
  logic              in_valid           = 1'b0;
  logic              in_stall;
  logic [LEN_W-1:0]  frame_length       = '0;
  logic              head_owned         = 1'b0;
  logic [2:0]        tx_process_state   = '0;
  logic              buffer_unavailable = 1'b0;
  logic              out_valid;
  logic              out_stall          = 1'b0;
  logic [SIZE_W-1:0] segment_size;
  logic              first_segment;
  logic              last_segment;
  logic [1:0]        status;
  logic              poll_demand;
  logic              clear_unavailable;

  descriptor_ledger ledger = new;

  int send_idle_pct  = 14;
  int recv_stall_pct = 47;
  int hold_requests  = 0;
  int holds_started  = 0;
  int hold_left      = 0;

  tx_frame_descriptor_segmenter_unit dut (.*);

  always #4 clk = ~clk;

  // Score both channels at the rising edge; an entry never shares an edge with its request.
  always @(posedge clk) begin : watch
    descriptor_t got;
    tx_request_t req;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.segment_size      = segment_size;
        got.first_segment     = first_segment;
        got.last_segment      = last_segment;
        got.status            = status;
        got.poll_demand       = poll_demand;
        got.clear_unavailable = clear_unavailable;
        ledger.check_entry(got);
      end
      if (in_valid && !in_stall) begin
        req.frame_length       = frame_length;
        req.head_owned         = head_owned;
        req.tx_process_state   = tx_process_state;
        req.buffer_unavailable = buffer_unavailable;
        ledger.note_request(req);
      end
    end
  end

  // Drive the entry-side stall: a requested hold-off runs its full length here, else random.
  always @(negedge clk) begin
    if (hold_requests != holds_started) begin
      holds_started++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic tx_request_t make_request(int len, bit owned, int tps, bit unavail);
    tx_request_t r;
    r.frame_length       = LEN_W'(len);
    r.head_owned         = owned;
    r.tx_process_state   = 3'(tps);
    r.buffer_unavailable = unavail;
    return r;
  endfunction

  // Favor short frames and segment boundaries; keep some zero, busy and oversize requests.
  function automatic tx_request_t random_request();
    tx_request_t r;
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 5)
      len = 0;
    else if (pick < 50)
      len = $urandom_range(3 * SEGMENT_BYTES, 1);
    else if (pick < 65)
      len = $urandom_range(MAX_SEGMENTS, 1) * SEGMENT_BYTES - 1 + $urandom_range(2);
    else if (pick < 70)
      len = $urandom_range(65535, 65530);
    else
      len = $urandom_range(65535, 0);
    r.frame_length       = LEN_W'(len);
    r.head_owned         = ($urandom_range(9) == 0);
    r.tx_process_state   = ($urandom_range(3) == 0) ? TPS_SUSPENDED : 3'($urandom_range(7));
    r.buffer_unavailable = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic int pick_gap();
    int g;
    g = 0;
    while (g < MAX_GAP && $urandom_range(99) < send_idle_pct)
      g++;
    return g;
  endfunction

  // Offer one request after an idle gap and hold it until the block takes it.
  task automatic offer_request(input tx_request_t req, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid     = 1'b0;
      frame_length = LEN_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid           = 1'b1;
    frame_length       = req.frame_length;
    head_owned         = req.head_owned;
    tx_process_state   = req.tx_process_state;
    buffer_unavailable = req.buffer_unavailable;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic offer_random(input int n);
    for (int i = 0; i < n; i++)
      offer_request(random_request(), pick_gap());
  endtask

  // Drop valid and wait until every owed entry has come out, with a bound.
  task automatic wait_for_entries();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid = 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (ledger.queued.size() != 0 && waited < DRAIN_LIMIT);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: error precedence, segment boundaries, poll and clear conditions, oversize.
    offer_request(make_request(0, 0, 0, 0), pick_gap());
    offer_request(make_request(0, 1, 6, 1), pick_gap());
    offer_request(make_request(1, 1, 6, 1), pick_gap());
    offer_request(make_request(65535, 1, 0, 0), pick_gap());
    offer_request(make_request(1, 0, 6, 0), pick_gap());
    offer_request(make_request(1, 0, 0, 1), pick_gap());
    offer_request(make_request(1, 0, 5, 0), pick_gap());
    offer_request(make_request(1, 0, 7, 0), pick_gap());
    offer_request(make_request(SEGMENT_BYTES - 1, 0, 6, 1), pick_gap());
    offer_request(make_request(SEGMENT_BYTES, 0, 1, 1), pick_gap());
    offer_request(make_request(SEGMENT_BYTES + 1, 0, 6, 0), pick_gap());
    offer_request(make_request(2 * SEGMENT_BYTES, 0, 3, 0), pick_gap());
    offer_request(make_request(16'h5555, 0, 2, 1), pick_gap());
    offer_request(make_request(16'hAAAA, 0, 4, 0), pick_gap());
    offer_request(make_request(MAX_SEGMENTS * SEGMENT_BYTES, 0, 6, 1), pick_gap());
    offer_request(make_request(MAX_SEGMENTS * SEGMENT_BYTES + 1, 0, 6, 1), pick_gap());
    offer_request(make_request(65535, 0, 6, 1), pick_gap());
    wait_for_entries();

    // Phase one: light sender gaps, heavy entry stalls.
    offer_random(80);
    // Hold the entry side off while requests keep coming, so the block backs up.
    hold_requests++;
    for (int i = 0; i < PRESSURE_ITEMS; i++)
      offer_request(random_request(), 0);
    wait_for_entries();

    // Phase two: roles swapped, with one full pause in the middle.
    send_idle_pct  = 47;
    recv_stall_pct = 14;
    offer_random(40);
    wait_for_entries();
    offer_random(40);

    // Phase three: back to back on both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    offer_random(90);

    wait_for_entries();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.queued.size() != 0) begin
      ledger.mismatches++;
      $display("%0t: %0d entries expected but never seen", $time, ledger.queued.size());
    end

    $display("run: %0d requests (%0d rejected), %0d entries, up to %0d entries per frame",
             ledger.requests_seen, ledger.rejected_seen, ledger.entries_seen,
             ledger.most_entries);
    $display("run: sender/receiver idling 14/47, 47/14 and none, one %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (ledger.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Bound the run well beyond the slowest correct case.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/tfds_pkg.sv
rtl/core/tfds_ctrl.sv
rtl/core/tfds_dp.sv
rtl/core/tx_frame_descriptor_segmenter_unit.sv
tb/tb_tx_frame_descriptor_segmenter_unit.sv
